// ===== rtl/utf8_word_script_splitter_unit_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef UTF8_WORD_SCRIPT_SPLITTER_UNIT_MACROS_SVH
`define UTF8_WORD_SCRIPT_SPLITTER_UNIT_MACROS_SVH

// Checked only while out of reset
`define U8WS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("utf8ws assertion failed");

// Checked at every edge, reset included
`define U8WS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("utf8ws assertion failed");

`endif

// ===== rtl/utf8ws_pkg.sv =====
// Shared types and classification functions of the UTF-8 word/script splitter
`timescale 1ns / 1ps
`default_nettype none

package utf8ws_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned QDepth = 4;

  localparam logic [LenW-1:0] LenMax = '1;

  // Finished token summary handed from the front end to the back end
  typedef struct packed {
    logic [LenW-1:0] length;
    logic            decided;   // at least one script letter seen
    logic            russian;   // cyrillic count >= latin count
    logic            fallback;  // fallback language latched for this string
    logic            last;
  } entry_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_cyrillic(input logic [CpW-1:0] cp);
    return ((cp >= 21'h00400) && (cp <= 21'h0052F)) ||
           ((cp >= 21'h02DE0) && (cp <= 21'h02DFF)) ||
           ((cp >= 21'h0A640) && (cp <= 21'h0A69F));
  endfunction

  function automatic logic is_latin(input logic [CpW-1:0] cp);
    return ((cp >= 21'h00041) && (cp <= 21'h0005A)) ||
           ((cp >= 21'h00061) && (cp <= 21'h0007A));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8ws_front.sv =====
// Front end: byte intake, token cutting, UTF-8 decode and script counters
`timescale 1ns / 1ps
`default_nettype none

module utf8ws_front #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  fallback_i,
  input  wire                  accept_i,
  input  wire  [7:0]           byte_i,
  input  wire                  eos_i,
  output logic                 push_a_o,
  output utf8ws_pkg::entry_t   entry_a_o,
  output logic                 push_b_o,
  output utf8ws_pkg::entry_t   entry_b_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic                        open_q, open_d;
  logic                        trail_q, trail_d;
  logic                        fb_q, fb_d;
  logic [utf8ws_pkg::LenW-1:0] bytes_q, bytes_d;
  logic [COUNT_BITS-1:0]       cyr_q, cyr_d, lat_q, lat_d;
  logic [1:0]                  cont_q, cont_d;
  logic [utf8ws_pkg::CpW-1:0]  part_q, part_d;

  logic                        sp, fresh, boundary;
  logic                        base_trail;
  logic [utf8ws_pkg::LenW-1:0] base_bytes;
  logic [COUNT_BITS-1:0]       base_cyr, base_lat;
  logic [1:0]                  base_cont;
  logic [utf8ws_pkg::CpW-1:0]  base_part;
  logic                        cp_valid;
  logic [utf8ws_pkg::CpW-1:0]  cp;
  logic                        hit_cyr, hit_lat;

  always_comb begin
    sp       = utf8ws_pkg::is_space(byte_i);
    boundary = open_q && trail_q && !sp;
    fresh    = !open_q || boundary;
    fb_d     = open_q ? fb_q : fallback_i;

    base_trail = fresh ? 1'b0 : trail_q;
    base_bytes = fresh ? '0 : bytes_q;
    base_cyr   = fresh ? '0 : cyr_q;
    base_lat   = fresh ? '0 : lat_q;
    base_cont  = fresh ? '0 : cont_q;
    base_part  = fresh ? '0 : part_q;

    // decode step; a broken sequence yields no code point, so it counts for neither script
    cp_valid = 1'b0;
    cp       = '0;
    cont_d   = base_cont;
    part_d   = base_part;
    if (base_cont != 2'd0) begin
      if (byte_i[7:6] == 2'b10) begin
        part_d = {base_part[utf8ws_pkg::CpW-7:0], byte_i[5:0]};
        cont_d = base_cont - 2'd1;
        if (cont_d == 2'd0) begin
          cp_valid = 1'b1;
          cp       = part_d;
        end
      end else begin
        cont_d = 2'd0;
      end
    end else if (!byte_i[7]) begin
      cp_valid = 1'b1;
      cp       = {13'd0, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      part_d = {16'd0, byte_i[4:0]};
      cont_d = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      part_d = {17'd0, byte_i[3:0]};
      cont_d = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      part_d = {18'd0, byte_i[2:0]};
      cont_d = 2'd3;
    end

    hit_cyr = cp_valid && utf8ws_pkg::is_cyrillic(cp);
    hit_lat = cp_valid && utf8ws_pkg::is_latin(cp);
    cyr_d   = base_cyr + COUNT_BITS'(hit_cyr && (base_cyr != CountMax));
    lat_d   = base_lat + COUNT_BITS'(hit_lat && (base_lat != CountMax));
    bytes_d = base_bytes + utf8ws_pkg::LenW'(base_bytes != utf8ws_pkg::LenMax);
    trail_d = base_trail | sp;
    open_d  = !eos_i;

    push_a_o           = accept_i && boundary;
    entry_a_o.length   = bytes_q;
    entry_a_o.decided  = (cyr_q != '0) || (lat_q != '0);
    entry_a_o.russian  = cyr_q >= lat_q;
    entry_a_o.fallback = fb_q;
    entry_a_o.last     = 1'b0;

    push_b_o           = accept_i && eos_i;
    entry_b_o.length   = bytes_d;
    entry_b_o.decided  = (cyr_d != '0) || (lat_d != '0);
    entry_b_o.russian  = cyr_d >= lat_d;
    entry_b_o.fallback = fb_d;
    entry_b_o.last     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      trail_q <= 1'b0;
      fb_q    <= 1'b0;
      bytes_q <= '0;
      cyr_q   <= '0;
      lat_q   <= '0;
      cont_q  <= '0;
      part_q  <= '0;
    end else if (accept_i) begin
      open_q  <= open_d;
      trail_q <= trail_d;
      fb_q    <= fb_d;
      bytes_q <= bytes_d;
      cyr_q   <= cyr_d;
      lat_q   <= lat_d;
      cont_q  <= cont_d;
      part_q  <= part_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8ws_queue.sv =====
// Token queue between front and back end; takes up to two entries a cycle
`timescale 1ns / 1ps
`default_nettype none

module utf8ws_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_a_i,
  input  utf8ws_pkg::entry_t  entry_a_i,
  input  wire                 push_b_i,
  input  utf8ws_pkg::entry_t  entry_b_i,
  output logic                room_o,
  output logic                head_valid_o,
  output utf8ws_pkg::entry_t  head_o,
  input  wire                 pop_i
);

  localparam int unsigned PtrW = $clog2(utf8ws_pkg::QDepth);
  localparam int unsigned CntW = $clog2(utf8ws_pkg::QDepth + 1);

  utf8ws_pkg::entry_t mem_q [utf8ws_pkg::QDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]         n_push;
  utf8ws_pkg::entry_t slot0;

  always_comb begin
    n_push = {1'b0, push_a_i} + {1'b0, push_b_i};
    slot0  = push_a_i ? entry_a_i : entry_b_i;
    wr_d   = wr_q + PtrW'(n_push);
    rd_d   = rd_q + PtrW'(pop_i);
    cnt_d  = cnt_q + CntW'(n_push) - CntW'(pop_i);
    // room for a full two-entry request
    room_o       = cnt_q <= CntW'(utf8ws_pkg::QDepth - 2);
    head_valid_o = cnt_q != '0;
    head_o       = mem_q[rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i || push_b_i) begin
      mem_q[wr_q] <= slot0;
    end
    if (push_a_i && push_b_i) begin
      mem_q[wr_q + PtrW'(1)] <= entry_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8ws_back.sv =====
// Back end: language resolution, segment joining and output register
`timescale 1ns / 1ps
`default_nettype none

module utf8ws_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         head_valid_i,
  input  utf8ws_pkg::entry_t          head_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  wire                         ready_i,
  output logic [utf8ws_pkg::LenW-1:0] length_o,
  output logic                        language_o,
  output logic                        joins_o,
  output logic                        last_o
);

  logic                        valid_q, valid_d;
  logic                        any_q, any_d;
  logic                        prev_q, prev_d;
  logic [utf8ws_pkg::LenW-1:0] len_q;
  logic                        lang_q, joins_q, last_q;
  logic                        prev_eff, lang, joins;

  always_comb begin
    // before the first token of a string the latched fallback stands in
    prev_eff = any_q ? prev_q : head_i.fallback;
    lang     = head_i.decided ? head_i.russian : prev_eff;
    joins    = any_q && (lang == prev_eff);
    pop_o    = head_valid_i && (!valid_q || ready_i);
    valid_d  = pop_o || (valid_q && !ready_i);
    any_d    = any_q;
    prev_d   = prev_q;
    if (pop_o) begin
      any_d  = !head_i.last;
      prev_d = lang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      any_q   <= 1'b0;
      prev_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      any_q   <= any_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      len_q   <= head_i.length;
      lang_q  <= lang;
      joins_q <= joins;
      last_q  <= head_i.last;
    end
  end

  assign valid_o    = valid_q;
  assign length_o   = len_q;
  assign language_o = lang_q;
  assign joins_o    = joins_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// ===== rtl/utf8_word_script_splitter_unit.sv =====
// Top level of the UTF-8 word/script splitter
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata = text_byte, tlast = end_of_string
//  m_axis    out  tvalid/tready          tdata = token_length,
//                                        tuser = {joins_segment, language}, tlast = last
//  cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i = fallback_language
//
//  One byte per cycle while s_axis_tready is high; a byte is decoded and counted in
//  the cycle it is taken. A byte may finish two tokens; the four-entry token queue
//  then absorbs the burst and the output register drains one token per cycle while
//  m_axis_tready is high. With queue and output register empty, a token enters the
//  queue at the edge that takes the byte closing it and is then loaded into the
//  output register. s_axis_tready drops only when the queue has fewer than two free
//  entries. Reset clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf8_word_script_splitter_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] token_length
  output logic [1:0]  m_axis_tuser,   // [0] language, [1] joins_segment
  output logic        m_axis_tlast,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [0:0]  cfg_data_i      // [0] fallback_language
);

  logic               fallback_q;
  logic               accept;
  logic               push_a, push_b, room, head_valid, pop;
  utf8ws_pkg::entry_t entry_a, entry_b, head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fallback_q <= cfg_data_i[0];
    end
  end

  utf8ws_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fallback_i(fallback_q),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata),
    .eos_i     (s_axis_tlast),
    .push_a_o  (push_a),
    .entry_a_o (entry_a),
    .push_b_o  (push_b),
    .entry_b_o (entry_b)
  );

  utf8ws_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (push_a),
    .entry_a_i   (entry_a),
    .push_b_i    (push_b),
    .entry_b_i   (entry_b),
    .room_o      (room),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  utf8ws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .length_o    (m_axis_tdata),
    .language_o  (m_axis_tuser[0]),
    .joins_o     (m_axis_tuser[1]),
    .last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/utf8ws_checker.sv =====
// Port-level checker for the splitter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_word_script_splitter_unit_macros.svh"

module utf8ws_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  logic [18:0] out_word;

  assign out_word = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `U8WS_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `U8WS_ASSERT(a_out_stable, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(out_word))
  `U8WS_ASSERT(a_len_nonzero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata != 16'd0))
  `U8WS_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> (m_axis_tvalid !== 1'b1))

endmodule

bind utf8_word_script_splitter_unit utf8ws_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/utf8_word_script_splitter_unit_tb.sv =====
// Testbench: byte stream, token predictor and checker for the UTF-8 word/script splitter
`timescale 1ns / 1ps

module utf8_word_script_splitter_unit_tb;

  localparam int unsigned CountBits  = 16;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned PhaseBytes = 300;
  localparam int unsigned DirRows    = 27;

  localparam logic [CountBits-1:0] CountMax    = '1;
  localparam logic [15:0]          LenMax      = 16'hFFFF;
  localparam logic [20:0]          Replacement = 21'h00FFFD;

  localparam logic [7:0] WsBytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // code points on both sides of the script range boundaries, but for 2DFF and A640
  localparam logic [20:0] EdgePoints [16] = '{
    21'h0040, 21'h0041, 21'h005A, 21'h005B, 21'h0060, 21'h0061, 21'h007A, 21'h007B,
    21'h03FF, 21'h0400, 21'h052F, 21'h0530, 21'h2DDF, 21'h2DE0, 21'hA69F, 21'hA6A0
  };

  typedef enum logic [1:0] {RxFree, RxBusy, RxSparse, RxPulsed} rx_mode_e;
  typedef enum logic [1:0] {ScriptMixed, ScriptLatin, ScriptCyrillic} script_bias_e;

  typedef struct packed {
    logic [15:0] len;
    logic        lang;
    logic        joins;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0]  text;
    logic        eos;
    logic        typed;   // expected token written out below
    logic [15:0] len;
    logic        lang;
    logic        joins;
  } dir_row_t;

  // fallback stays 0 throughout this table
  localparam dir_row_t DirectedRows [DirRows] = '{
    '{8'h61, 1'b1, 1'b1, 16'd1, 1'b0, 1'b0},   // lone ASCII letter
    '{8'h20, 1'b1, 1'b1, 16'd1, 1'b0, 1'b0},   // whitespace-only string
    '{8'hD0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h94, 1'b1, 1'b1, 16'd2, 1'b1, 1'b0},   // two-byte Cyrillic
    '{8'hFF, 1'b1, 1'b1, 16'd1, 1'b0, 1'b0},   // bad lead byte
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h09, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h7A, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h0D, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h5A, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h41, 1'b1, 1'b1, 16'd2, 1'b0, 1'b0},   // bad continuation eats the letter
    '{8'hF0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 16'd4, 1'b0, 1'b0},   // U+10000, no script
    '{8'hE2, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hB7, 1'b1, 1'b1, 16'd2, 1'b0, 1'b0},   // sequence cut off by end of string
    '{8'hEA, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h99, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hF8, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h0C, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h41, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hD0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h20, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},   // whitespace as bad continuation
    '{8'h61, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_data_i = 1'b0;

  utf8_word_script_splitter_unit #(
    .COUNT_BITS(CountBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // token predictor state
  logic                 fallback_lang = 1'b0;
  logic                 prev_lang = 1'b0;
  logic                 tok_open = 1'b0;
  logic                 emitted_any = 1'b0;
  logic                 trailing_ws = 1'b0;
  logic [15:0]          tok_len = '0;
  logic [CountBits-1:0] cyr_count = '0;
  logic [CountBits-1:0] lat_count = '0;
  logic [1:0]           cont_left = '0;
  logic [20:0]          cp_acc = '0;

  token_t     expected_tokens[$];
  logic [7:0] text_q[$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b1;

  function automatic void append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void tally_codepoint(input logic [20:0] cp);
    if ((cp >= 21'h0400 && cp <= 21'h052F) || (cp >= 21'h2DE0 && cp <= 21'h2DFF) ||
        (cp >= 21'hA640 && cp <= 21'hA69F)) begin
      if (cyr_count != CountMax) cyr_count++;
    end else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) begin
      if (lat_count != CountMax) lat_count++;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) tally_codepoint(cp_acc);
      end else begin
        cont_left = 0;
        tally_codepoint(Replacement);
      end
    end else if (!b[7]) begin
      tally_codepoint({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      tally_codepoint(Replacement);
    end
  endfunction

  function automatic void open_token();
    tok_open = 1'b1;
    trailing_ws = 1'b0;
    tok_len = '0;
    cyr_count = '0;
    lat_count = '0;
    cont_left = '0;
    cp_acc = '0;
  endfunction

  function automatic void close_token(input logic is_last);
    token_t t;
    logic lang;
    if (cyr_count == 0 && lat_count == 0) lang = prev_lang;
    else lang = (cyr_count >= lat_count);
    t.len = tok_len;
    t.lang = lang;
    t.joins = emitted_any && (lang == prev_lang);
    t.last = is_last;
    expected_tokens.insert(expected_tokens.size(), t);
    prev_lang = lang;
    emitted_any = 1'b1;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eos);
    logic ws;
    ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    if (!tok_open) begin
      prev_lang = fallback_lang;
      emitted_any = 1'b0;
      open_token();
    end else if (trailing_ws && !ws) begin
      close_token(1'b0);
      open_token();
    end
    if (ws) trailing_ws = 1'b1;
    if (tok_len != LenMax) tok_len++;
    decode_byte(b);
    if (eos) begin
      close_token(1'b1);
      tok_open = 1'b0;
      emitted_any = 1'b0;
      trailing_ws = 1'b0;
      cont_left = '0;
      cp_acc = '0;
      prev_lang = fallback_lang;
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eos;
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic write_fallback(input logic val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    fallback_lang = val;
  endtask

  // let the block go idle before touching the register
  task automatic drain_then_write(input logic val);
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_fallback(val);
    burst_left = 0;
  endtask

  task automatic put_codepoint(input logic [20:0] cp, input int nb);
    logic [7:0] seq [4];
    int cut;
    case (nb)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    // now and then drop the final continuation byte
    cut = (nb > 1 && $urandom_range(0, 15) == 0) ? 1 : 0;
    for (int i = 0; i < nb - cut; i++) append_byte(seq[i]);
  endtask

  task automatic add_glyph(input script_bias_e bias);
    int kind;
    logic [20:0] cp;
    kind = $urandom_range(0, 13);
    if (bias == ScriptLatin && $urandom_range(0, 4) != 0) kind = 0;
    if (bias == ScriptCyrillic && $urandom_range(0, 4) != 0) kind = 4;
    case (kind)
      0, 1, 2: begin
        cp = 21'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 21'h41 : 21'h61);
        put_codepoint(cp, 1);
      end
      3: put_codepoint(21'($urandom_range(0, 127)), 1);
      4, 5, 6: put_codepoint(21'($urandom_range(21'h0400, 21'h052F)), 2);
      7: begin
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(21'h2DE0, 21'h2DFF));
          1: cp = 21'($urandom_range(21'hA640, 21'hA69F));
          default: cp = 21'($urandom_range(21'h0800, 21'hFFFF));
        endcase
        put_codepoint(cp, 3);
      end
      8: put_codepoint(21'($urandom_range(0, 21'h07FF)), 2);   // overlong forms too
      9: put_codepoint(21'($urandom_range(0, 21'h1FFFFF)), 4);
      10: put_codepoint(21'($urandom_range(0, 21'hFFFF)), 3);  // surrogates too
      11: begin
        cp = EdgePoints[$urandom_range(0, 15)];
        put_codepoint(cp, (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : 3);
      end
      default: append_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_string();
    int words;
    int glyphs;
    script_bias_e bias;
    text_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) append_byte(WsBytes[$urandom_range(0, 5)]);
    end
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      bias = script_bias_e'($urandom_range(0, 2));
      glyphs = $urandom_range(1, 6);
      repeat (glyphs) add_glyph(bias);
      repeat ($urandom_range((w == words - 1) ? 0 : 1, 3)) begin
        append_byte(WsBytes[$urandom_range(0, 5)]);
      end
    end
  endtask

  task automatic send_string();
    logic eos;
    foreach (text_q[i]) begin
      eos = (i == text_q.size() - 1);
      predict_byte(text_q[i], eos);
      push_byte(text_q[i], eos);
    end
  endtask

  initial begin
    token_t typed_tok;
    int phase_bytes;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      predict_byte(DirectedRows[i].text, DirectedRows[i].eos);
      if (DirectedRows[i].typed) begin
        typed_tok = '{DirectedRows[i].len, DirectedRows[i].lang, DirectedRows[i].joins, 1'b1};
        expected_tokens[expected_tokens.size() - 1] = typed_tok;
      end
      push_byte(DirectedRows[i].text, DirectedRows[i].eos);
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain_then_write(phase % 2 == 0);
      gaps_on = (phase != 3);
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        build_string();
        phase_bytes += text_q.size();
        send_string();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // receiver backpressure, switching between modes of its own
  rx_mode_e rx_mode = RxFree;
  int       rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree:   m_axis_tready <= 1'b1;
      RxBusy:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= rx_left[2];
    endcase
  end

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with no request pending: length %0d", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (m_axis_tdata !== want.len) begin
          $error("token_length: expected %0d, actual %0d", want.len, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.lang) begin
          $error("language: expected %0d, actual %0d", want.lang, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[1] !== want.joins) begin
          $error("joins_segment: expected %0d, actual %0d", want.joins, m_axis_tuser[1]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
           (cfg_valid_i && cfg_ready_o)) === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/utf8ws_pkg.sv
rtl/utf8ws_front.sv
rtl/utf8ws_queue.sv
rtl/utf8ws_back.sv
rtl/utf8_word_script_splitter_unit.sv
rtl/utf8ws_checker.sv
tb/sv/utf8_word_script_splitter_unit_tb.sv
